// ===== hw/rtl/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

  localparam int unsigned COEFS = 12;
  localparam int unsigned POS_W = 32;
  localparam int unsigned WGT_W = 17;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned TERM_W = 50;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_INFL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_WGT,
    ST_ACC,
    ST_OUT
  } lbs_state_t;

  typedef struct packed {
    logic       clr_row;
    logic       mac_en;
    logic       wgt_en;
    logic       acc_en;
    logic       acc_clr;
    logic       out_load;
    logic [1:0] row;
    logic [1:0] col;
  } lbs_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lbs_ctrl.sv =====
`default_nettype none
module lbs_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_fire,
  input  wire              infl,
  input  wire              out_busy,
  output logic             in_ready,
  output lbs_pkg::lbs_cmd_t cmd
);
  import lbs_pkg::*;

  lbs_state_t state_r, state_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;

  // hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // sequence one row at a time: three products plus translation, weight, add
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.col   = col_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && infl) begin
          state_nxt = ST_READ;
          row_nxt   = '0;
          col_nxt   = '0;
        end
      end
      ST_READ: begin
        cmd.clr_row = 1'b1;
        state_nxt   = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (col_r == 2'd3) begin
          col_nxt   = '0;
          state_nxt = ST_WGT;
        end else begin
          col_nxt = col_r + 2'd1;
        end
      end
      ST_WGT: begin
        cmd.wgt_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (row_r == 2'd2) begin
          state_nxt = ST_OUT;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = ST_READ;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/lbs_datapath.sv =====
`default_nettype none
module lbs_datapath #(
  parameter int unsigned MAX_BONES = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_fire,
  input  wire                      req_type,
  input  wire  [5:0]               bone_index,
  input  wire  [3:0]               coef_index,
  input  wire  [31:0]              coef_value,
  input  wire  [31:0]              pos_x,
  input  wire  [31:0]              pos_y,
  input  wire  [31:0]              pos_z,
  input  wire  [16:0]              weight,
  input  wire                      last_influence,
  input  wire  lbs_pkg::lbs_cmd_t  cmd,
  output logic                     out_busy,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [95:0]              out_data
);
  import lbs_pkg::*;

  localparam int unsigned DEPTH = MAX_BONES * COEFS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [16:0]        w_r;
  logic               live_r, last_r;
  logic signed [TERM_W-1:0] t_r;
  logic signed [ACC_W-1:0]  scaled_r;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic [AW-1:0]      base_r;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] psel;
  logic signed [PROD_W-1:0] prod;
  logic signed [TERM_W-1:0] t_add;
  logic signed [TERM_W-1:0] hi;
  logic [15:0]        lo;
  logic signed [ACC_W-1:0]  sc;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic [31:0]        sat_o [3];

  assign waddr = AW'(({26'd0, bone_index} * COEFS) + {28'd0, coef_index});
  assign raddr = base_r + AW'({cmd.row, 2'b00} + {2'b00, cmd.col});

  // write table on load beats, read one coefficient a cycle
  always_ff @(posedge clk) begin
    if (in_fire && req_type == REQ_LOAD && {26'd0, bone_index} < MAX_BONES
        && coef_index < COEFS) begin
      mem[waddr] <= coef_value;
    end
    rd_r <= mem[raddr];
  end

  // capture influence operands
  always_ff @(posedge clk) begin
    if (in_fire && req_type == REQ_INFL) begin
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      w_r    <= weight;
      base_r <= AW'({26'd0, bone_index} * COEFS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      last_r <= 1'b0;
    end else if (in_fire && req_type == REQ_INFL) begin
      live_r <= {26'd0, bone_index} < MAX_BONES;
      last_r <= last_influence;
    end
  end

  // column product; rd_r holds coefficient for previous column
  always_comb begin
    case (cmd.col)
      2'd1:    psel = px_r;
      2'd2:    psel = py_r;
      default: psel = pz_r;
    endcase
    prod = rd_r * psel;
    if (cmd.col == 2'd0) t_add = TERM_W'(0);
    else if (cmd.col == 2'd1 || cmd.col == 2'd2 || cmd.col == 2'd3)
      t_add = TERM_W'(prod >>> 16);
    else t_add = TERM_W'(0);
  end

  // row term: column 0 slot reads coef 0; products land in the cycle after the read
  always_ff @(posedge clk) begin
    if (cmd.clr_row) begin
      t_r <= '0;
    end else if (cmd.mac_en) begin
      if (cmd.col != 2'd0) t_r <= t_r + t_add;
    end
  end

  // weight: hi*w + (lo*w)>>16, using translation read in the mac tail
  logic signed [TERM_W-1:0] t_fin;
  always_comb begin
    t_fin = t_r + TERM_W'(rd_r);
    hi    = t_fin >>> 16;
    lo    = t_fin[15:0];
    sc    = ACC_W'(hi) * $signed({1'b0, w_r})
            + ACC_W'($signed({1'b0, ({16'd0, lo} * {16'd0, w_r}) >> 16}));
  end

  // register the weighted row for the add cycle
  always_ff @(posedge clk) begin
    if (cmd.wgt_en) scaled_r <= sc;
  end

  // saturating accumulate
  always_comb begin
    sum = {acc_r[cmd.row][ACC_W-1], acc_r[cmd.row]} + {scaled_r[ACC_W-1], scaled_r};
    if (sum[ACC_W] != sum[ACC_W-1])
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else sum_sat = sum[ACC_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (acc_r[i] > 64'sd2147483647) sat_o[i] = 32'h7fffffff;
      else if (acc_r[i] < -64'sd2147483648) sat_o[i] = 32'h80000000;
      else sat_o[i] = acc_r[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc_en && live_r) acc_r[cmd.row] <= sum_sat;
      if (cmd.out_load && last_r) begin
        out_valid <= 1'b1;
        out_data  <= {sat_o[2], sat_o[1], sat_o[0]};
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

// ===== hw/rtl/linear_blend_skinning.sv =====
`default_nettype none
// Linear blend skinning, fixed point.
// Input stream in_*: one beat is a coefficient load (tuser=0) or a vertex
// influence (tuser=1); tlast marks the last influence of a vertex.
// A load writes the per-bone transform memory and leaves the input ready.
// An influence walks three rows; each row reads four coefficients from the
// transform memory, multiplies three of them through one shared 32x32
// multiplier, adds the fourth as translation, weights the row and adds it
// to a 64-bit saturating lane. An influence holds the input from its accept
// through the row work until the result is handed off.
// On the last influence the saturated position is registered on out_*,
// lanes are cleared, and the next beat is accepted while the result waits.
// If the receiver still holds that result when the next influence finishes,
// the block holds until the registered result is taken. Reset (rst_n low,
// synchronous) clears the lanes and the handshake; the transform memory is
// undefined until loaded.
module linear_blend_skinning #(
  parameter int unsigned MAX_BONES = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata: bone_index[5:0], coef_index[9:6], coef_value[41:10], pos_x[73:42],
  // pos_y[105:74], pos_z[137:106], weight[154:138], zero fill to 160
  input  wire  [159:0] in_tdata,
  input  wire          in_tuser,  // req_type
  input  wire          in_tlast,  // last_influence
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  out_tdata
);
  import lbs_pkg::*;

  lbs_cmd_t cmd;
  logic     in_fire, out_busy;

  assign in_fire = in_tvalid && in_tready;

  lbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .infl(in_tuser == REQ_INFL),
    .out_busy(out_busy), .in_ready(in_tready), .cmd(cmd)
  );

  lbs_datapath #(.MAX_BONES(MAX_BONES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .req_type(in_tuser),
    .bone_index(in_tdata[5:0]), .coef_index(in_tdata[9:6]),
    .coef_value(in_tdata[41:10]), .pos_x(in_tdata[73:42]),
    .pos_y(in_tdata[105:74]), .pos_z(in_tdata[137:106]),
    .weight(in_tdata[154:138]), .last_influence(in_tlast), .cmd(cmd),
    .out_busy(out_busy), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata)
  );

`ifndef SYNTHESIS
  a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mac_en || cmd.acc_en) |-> !in_tready) else $error("accept during row work");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_row, cmd.mac_en, cmd.wgt_en, cmd.acc_en, cmd.out_load}))
    else $error("overlapping commands");
`endif
endmodule
`default_nettype wire
